>>> rtl/core/sfir_pkg.sv
// shared types, constants and coefficient table of the symmetric fir filter
package sfir_pkg;

    // sample and arithmetic widths
    localparam int SAMPLE_WIDTH    = 16;
    localparam int COEF_WIDTH      = 16;
    localparam int COEF_FRAC_BITS  = 15;
    localparam int SUM_WIDTH       = SAMPLE_WIDTH + 1;
    localparam int PROD_WIDTH      = SUM_WIDTH + COEF_WIDTH;
    localparam int ACC_WIDTH       = 40;
    localparam int NUM_COEFS       = 25;
    localparam int COEF_IDX_WIDTH  = 8;
    localparam int DELAY_DEPTH_DEF = 49;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_WIDTH-1:0]   t_coef;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_ctrl_state;

    // one tap-pair step handed from the sequencer to the datapath
    typedef struct packed {
        logic                      valid;
        logic                      first;
        logic                      last;
        logic                      use_x0;
        logic                      keep_a;
        logic                      keep_b;
        logic [COEF_IDX_WIDTH-1:0] coef_idx;
    } t_step;

    // low-pass coefficients in q1.15, zero beyond the listed half
    function automatic t_coef coef_value(input logic [COEF_IDX_WIDTH-1:0] idx);
        t_coef c;
        case (idx)
            8'd0:    c = -16'sd732;
            8'd1:    c = 16'sd1;
            8'd2:    c = 16'sd16;
            8'd3:    c = 16'sd41;
            8'd4:    c = 16'sd77;
            8'd5:    c = 16'sd123;
            8'd6:    c = 16'sd178;
            8'd7:    c = 16'sd242;
            8'd8:    c = 16'sd315;
            8'd9:    c = 16'sd396;
            8'd10:   c = 16'sd484;
            8'd11:   c = 16'sd577;
            8'd12:   c = 16'sd673;
            8'd13:   c = 16'sd773;
            8'd14:   c = 16'sd873;
            8'd15:   c = 16'sd972;
            8'd16:   c = 16'sd1067;
            8'd17:   c = 16'sd1157;
            8'd18:   c = 16'sd1242;
            8'd19:   c = 16'sd1317;
            8'd20:   c = 16'sd1382;
            8'd21:   c = 16'sd1436;
            8'd22:   c = 16'sd1478;
            8'd23:   c = 16'sd1506;
            8'd24:   c = 16'sd1520;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/sfir_mem.sv
// delay line storage: one write port and two registered read ports
module sfir_mem #(
    parameter int  DEPTH = sfir_pkg::DELAY_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_wr_addr,
    input  sfir_pkg::t_sample     i_wr_data,
    input  logic [AW-1:0]         i_rd_addr_a,
    input  logic [AW-1:0]         i_rd_addr_b,
    output sfir_pkg::t_sample     o_rd_data_a,
    output sfir_pkg::t_sample     o_rd_data_b
);

    sfir_pkg::t_sample r_mem [DEPTH];
    sfir_pkg::t_sample r_rd_a;
    sfir_pkg::t_sample r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> rtl/core/sfir_ctrl.sv
// sequencer: takes an item, walks the mirrored tap pairs, writes the new sample
module sfir_ctrl #(
    parameter int  DELAY_DEPTH = sfir_pkg::DELAY_DEPTH_DEF,
    localparam int PTR_W       = $clog2(DELAY_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  sfir_pkg::t_sample     i_sample_in,
    output logic                  o_in_stall,
    output sfir_pkg::t_sample     o_x0,
    output logic [PTR_W-1:0]      o_rd_addr_a,
    output logic [PTR_W-1:0]      o_rd_addr_b,
    output logic                  o_we,
    output logic [PTR_W-1:0]      o_wr_addr,
    output sfir_pkg::t_sample     o_wr_data,
    output sfir_pkg::t_step       o_step,
    input  logic                  i_done
);

    localparam int         NUM_STEPS = DELAY_DEPTH / 2 + 1;
    localparam int         K_W       = $clog2(NUM_STEPS);
    localparam bit         MID_ALONE = (DELAY_DEPTH % 2) == 0;
    localparam [K_W-1:0]   LAST_K    = K_W'(NUM_STEPS - 1);
    localparam [K_W-1:0]   WRITE_K   = K_W'(1);
    localparam [PTR_W-1:0] LAST_PTR  = PTR_W'(DELAY_DEPTH - 1);

    sfir_pkg::t_ctrl_state r_state, n_state;
    logic [K_W-1:0]        r_k, n_k;
    logic [PTR_W-1:0]      r_pa, n_pa;
    logic [PTR_W-1:0]      r_pb, n_pb;
    logic [PTR_W-1:0]      r_wp, n_wp;
    logic                  r_wrapped, n_wrapped;
    sfir_pkg::t_sample     r_x0, n_x0;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sfir_pkg::ST_IDLE;
            r_k       <= '0;
            r_pa      <= '0;
            r_pb      <= '0;
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_pa      <= n_pa;
            r_pb      <= n_pb;
            r_wp      <= n_wp;
            r_wrapped <= n_wrapped;
        end
    end

    // held input sample
    always_ff @(posedge i_clk) begin
        r_x0 <= n_x0;
    end

    // next state and step issue
    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_pa      = r_pa;
        n_pb      = r_pb;
        n_wp      = r_wp;
        n_wrapped = r_wrapped;
        n_x0      = r_x0;
        o_step    = '0;
        o_we      = 1'b0;
        case (r_state)
            sfir_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sfir_pkg::ST_RUN;
                    n_k     = '0;
                    n_pa    = r_wp;
                    n_pb    = r_wp;
                    n_x0    = i_sample_in;
                end
            end
            sfir_pkg::ST_RUN: begin
                o_step.valid    = 1'b1;
                o_step.first    = (r_k == '0);
                o_step.last     = (r_k == LAST_K);
                o_step.use_x0   = (r_k == '0);
                // entries not yet written since reset read as zero
                o_step.keep_a   = r_wrapped || (r_pa < r_wp);
                o_step.keep_b   = (r_wrapped || (r_pb < r_wp)) &&
                                  !(MID_ALONE && (r_k == LAST_K));
                o_step.coef_idx = sfir_pkg::COEF_IDX_WIDTH'(r_k);
                // oldest entry is read at the first step, overwritten after it
                o_we            = (r_k == WRITE_K);
                n_k             = r_k + K_W'(1);
                n_pa            = (r_pa == '0) ? LAST_PTR : r_pa - PTR_W'(1);
                n_pb            = (r_pb == LAST_PTR) ? '0 : r_pb + PTR_W'(1);
                if (r_k == LAST_K) begin
                    n_state = sfir_pkg::ST_DRAIN;
                    n_wp    = (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
                    if (r_wp == LAST_PTR) begin
                        n_wrapped = 1'b1;
                    end
                end
            end
            sfir_pkg::ST_DRAIN: begin
                if (i_done) begin
                    n_state = sfir_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sfir_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != sfir_pkg::ST_IDLE);
    assign o_x0        = r_x0;
    assign o_rd_addr_a = r_pa;
    assign o_rd_addr_b = r_pb;
    assign o_wr_addr   = r_wp;
    assign o_wr_data   = r_x0;

endmodule

>>> rtl/core/sfir_mac.sv
// datapath: pre-add of a pair, coefficient multiply, accumulate, round and saturate
module sfir_mac (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfir_pkg::t_step       i_step,
    input  sfir_pkg::t_sample     i_x0,
    input  sfir_pkg::t_sample     i_rd_data_a,
    input  sfir_pkg::t_sample     i_rd_data_b,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output sfir_pkg::t_sample     o_sample_out,
    output logic                  o_done
);

    localparam int SW  = sfir_pkg::SAMPLE_WIDTH;
    localparam int AW  = sfir_pkg::ACC_WIDTH;
    localparam int FB  = sfir_pkg::COEF_FRAC_BITS;
    localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (FB - 1);
    localparam logic signed [AW-1:0] SAT_MAX    = AW'((1 << (SW - 1)) - 1);
    localparam logic signed [AW-1:0] SAT_MIN    = -SAT_MAX - AW'(1);

    sfir_pkg::t_step                            r_s1;
    logic                                       r_s2_valid, r_s2_first, r_s2_last;
    logic                                       r_s3_valid, r_s3_first, r_s3_last;
    logic signed [sfir_pkg::SUM_WIDTH-1:0]      r_sum, n_sum;
    sfir_pkg::t_coef                            r_coef;
    logic signed [sfir_pkg::PROD_WIDTH-1:0]     r_prod, n_prod;
    logic signed [AW-1:0]                       r_acc, n_acc;
    logic                                       r_acc_done;
    logic signed [AW-1:0]                       n_biased, n_shifted;
    sfir_pkg::t_sample                          r_rnd, n_rnd;
    logic                                       r_rnd_valid;
    sfir_pkg::t_sample                          r_out;
    logic                                       r_out_valid;
    sfir_pkg::t_sample                          n_a, n_b;
    logic                                       n_move;

    // step control follows the memory read latency and the datapath stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2_valid  <= 1'b0;
            r_s2_first  <= 1'b0;
            r_s2_last   <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s3_first  <= 1'b0;
            r_s3_last   <= 1'b0;
            r_acc_done  <= 1'b0;
            r_rnd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1        <= i_step;
            r_s2_valid  <= r_s1.valid;
            r_s2_first  <= r_s1.first;
            r_s2_last   <= r_s1.last;
            r_s3_valid  <= r_s2_valid;
            r_s3_first  <= r_s2_first;
            r_s3_last   <= r_s2_last;
            r_acc_done  <= r_s3_valid && r_s3_last;
            if (r_acc_done) begin
                r_rnd_valid <= 1'b1;
            end else if (n_move) begin
                r_rnd_valid <= 1'b0;
            end
            if (n_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pair pre-add with masking of unwritten entries
    always_comb begin
        n_a   = r_s1.use_x0 ? i_x0 : (r_s1.keep_a ? i_rd_data_a : '0);
        n_b   = r_s1.keep_b ? i_rd_data_b : '0;
        n_sum = sfir_pkg::SUM_WIDTH'(n_a) + sfir_pkg::SUM_WIDTH'(n_b);
    end

    // coefficient multiply
    always_comb begin
        n_prod = sfir_pkg::PROD_WIDTH'(r_sum) * sfir_pkg::PROD_WIDTH'(r_coef);
    end

    // accumulate, restarting at the first pair of an item
    always_comb begin
        n_acc = r_s3_first ? AW'(r_prod) : r_acc + AW'(r_prod);
    end

    // round half up then saturate to the sample range
    always_comb begin
        n_biased  = r_acc + ROUND_HALF;
        n_shifted = n_biased >>> FB;
        if (n_shifted > SAT_MAX) begin
            n_rnd = SW'(SAT_MAX);
        end else if (n_shifted < SAT_MIN) begin
            n_rnd = SW'(SAT_MIN);
        end else begin
            n_rnd = SW'(n_shifted);
        end
    end

    // result moves to the output register once it is free
    assign n_move = r_rnd_valid && (!r_out_valid || !i_out_stall);

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_coef <= sfir_pkg::coef_value(r_s1.coef_idx);
        r_prod <= n_prod;
        if (r_s3_valid) begin
            r_acc <= n_acc;
        end
        if (r_acc_done) begin
            r_rnd <= n_rnd;
        end
        if (n_move) begin
            r_out <= r_rnd;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;
    assign o_done       = n_move;

endmodule

>>> rtl/core/symmetric_fir_filter.sv
// top level of the symmetric linear-phase low-pass fir filter
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_sample_in  (signed q1.15)
//  output    out        o_out_valid / i_out_stall  o_sample_out (signed q1.15)
//
// an item runs one tap pair per cycle from its acceptance, then read, multiply, accumulate
// and round; the next item is accepted once its result has entered the output register
// reset clears the sequencer, the write pointer and the fill flag; unwritten delay line
// entries read as zero, so no clearing pass is needed
// a finished item waits in the output register while the next item runs; a new result
// is held back only while that register is still stalled
module symmetric_fir_filter #(
    parameter int DELAY_DEPTH = sfir_pkg::DELAY_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic signed [sfir_pkg::SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                                    o_in_stall,
    output logic                                    o_out_valid,
    output logic signed [sfir_pkg::SAMPLE_WIDTH-1:0] o_sample_out,
    input  logic                                    i_out_stall
);

    localparam int PTR_W = $clog2(DELAY_DEPTH);

    sfir_pkg::t_sample w_x0;
    sfir_pkg::t_sample w_rd_data_a;
    sfir_pkg::t_sample w_rd_data_b;
    sfir_pkg::t_sample w_wr_data;
    logic [PTR_W-1:0]  w_rd_addr_a;
    logic [PTR_W-1:0]  w_rd_addr_b;
    logic [PTR_W-1:0]  w_wr_addr;
    logic              w_we;
    sfir_pkg::t_step   w_step;
    logic              w_done;

    // sequencer
    sfir_ctrl #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_sample_in (i_sample_in),
        .o_in_stall  (o_in_stall),
        .o_x0        (w_x0),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b),
        .o_we        (w_we),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_step      (w_step),
        .i_done      (w_done)
    );

    // delay line
    sfir_mem #(
        .DEPTH (DELAY_DEPTH)
    ) u_mem (
        .i_clk       (i_clk),
        .i_we        (w_we),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_data_a),
        .o_rd_data_b (w_rd_data_b)
    );

    // multiply-accumulate datapath and output register
    sfir_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_x0         (w_x0),
        .i_rd_data_a  (w_rd_data_a),
        .i_rd_data_b  (w_rd_data_b),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .o_done       (w_done)
    );

`ifndef SYNTHESIS
    // an accepted item blocks the input in the next cycle
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not blocked after an item was accepted");

    // tap steps are issued only while an item is in flight
    a_step_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step.valid |-> o_in_stall)
        else $error("tap step issued with no item in flight");

    // the delay line is written only during a tap step, never at the first one
    a_write_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_step.valid && !w_step.first))
        else $error("delay line written outside the tap walk");

    // a result is handed over only for an item still in flight
    a_done_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (o_in_stall && !w_step.valid))
        else $error("result handed over with no item in flight");
`endif

endmodule

>>> tb/sfir_checker.sv
// checker of the symmetric fir filter: predicts every output sample and compares
module sfir_checker
    import sfir_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_stall,
    input  t_sample i_sample_in,
    input  logic    i_out_valid,
    input  logic    i_out_stall,
    input  t_sample i_sample_out,
    output int      o_errors,
    output int      o_pending
);

    localparam int DEPTH  = DELAY_DEPTH_DEF;
    localparam int NTAPS  = 25;
    localparam int FRAC   = 15;

    // low-pass taps in millionths, first half of the symmetric response
    localparam int TAP_MICRO [NTAPS] = '{
        -22345, 24, 477, 1261, 2341, 3740, 5422, 7399, 9625, 12098,
        14760, 17602, 20547, 23589, 26627, 29677, 32549, 35320, 37891, 40180,
        42183, 43828, 45099, 45957, 46392
    };

    longint  tap_q [NTAPS];
    t_sample hist [DEPTH];
    int      wr_pos;
    t_sample expected_out [$];
    int      mismatches;

    // quantize the taps to q1.15, half away from zero
    initial begin : quantize
        longint mag;
        mismatches = 0;
        for (int k = 0; k < NTAPS; k++) begin
            mag = (TAP_MICRO[k] < 0) ? -TAP_MICRO[k] : TAP_MICRO[k];
            mag = (mag * (longint'(1) << FRAC) + 500000) / 1000000;
            tap_q[k] = (TAP_MICRO[k] < 0) ? -mag : mag;
        end
    end

    // filter one new sample against the history, then store it over the oldest one
    function automatic t_sample filter_step(input t_sample x0);
        longint acc;
        longint newer;
        longint older;
        longint r;
        acc = 0;
        for (int k = 0; k < (DEPTH + 1) / 2; k++) begin
            newer = (k == 0) ? longint'(x0) : longint'(hist[(wr_pos + DEPTH - k) % DEPTH]);
            older = longint'(hist[(wr_pos + k) % DEPTH]);
            if (k < NTAPS)
                acc += tap_q[k] * (newer + older);
        end
        // round half up, drop the coefficient fraction, clamp to the sample range
        r = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        hist[wr_pos] = x0;
        wr_pos = (wr_pos + 1) % DEPTH;
        return t_sample'(r);
    endfunction

    // watch both channels at every edge
    always @(posedge i_clk) begin : watch
        t_sample want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++)
                hist[i] = '0;
            wr_pos = 0;
            expected_out.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_out.push_back(filter_step(i_sample_in));
            if (i_out_valid && !i_out_stall) begin
                if (expected_out.size() == 0) begin
                    if (mismatches < 10)
                        $display("output item %0d with no item outstanding", i_sample_out);
                    mismatches++;
                end else begin
                    want = expected_out.pop_front();
                    if (i_sample_out !== want) begin
                        if (mismatches < 10)
                            $display("sample_out mismatch: expected %0d, got %0d",
                                     want, i_sample_out);
                        mismatches++;
                    end
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_out.size();
    end

endmodule

>>> tb/tb.sv
// testbench top of the symmetric fir filter: stimulus, output stalls and verdict
module tb;
    import sfir_pkg::*;

    localparam int ITEMS = 1800;
    localparam int LIMIT = 1000000;

    localparam t_sample FULL_POS = 16'sh7fff;
    localparam t_sample FULL_NEG = 16'sh8000;

    // kinds of random segment
    typedef enum int {
        SEG_UNIFORM,
        SEG_SMALL,
        SEG_POS_FULL,
        SEG_NEG_FULL,
        SEG_ALTERNATE,
        SEG_NEAR_FULL
    } t_seg;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    t_sample i_sample_in;
    logic    o_in_stall;
    logic    o_out_valid;
    t_sample o_sample_out;
    logic    i_out_stall;

    int      fails;
    int      pending;
    int      sent;
    bit      idle_on;

    symmetric_fir_filter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_sample_in  (i_sample_in),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .i_out_stall  (i_out_stall)
    );

    sfir_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_sample_out (o_sample_out),
        .o_errors     (fails),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // offer one item, hold it through stalls, then maybe go idle
    task automatic send_sample(input t_sample s);
        int g;
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        g = idle_on ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every outstanding item has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // sample of a random segment
    function automatic t_sample seg_sample(input t_seg kind, input int idx);
        case (kind)
            SEG_SMALL:     return t_sample'($urandom_range(0, 511) - 256);
            SEG_POS_FULL:  return FULL_POS;
            SEG_NEG_FULL:  return FULL_NEG;
            SEG_ALTERNATE: return idx[0] ? FULL_NEG : FULL_POS;
            SEG_NEAR_FULL: return $urandom_range(0, 1) ? t_sample'(32767 - $urandom_range(0, 255))
                                                       : t_sample'(-32768 + $urandom_range(0, 255));
            default:       return t_sample'($urandom);
        endcase
    endfunction

    // output stalls: random bursts, with long stretches of none
    initial begin : out_stalls
        int hold_left;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
            end else if (i_out_stall) begin
                i_out_stall <= 1'b0;
                hold_left = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 600)
                                                         : $urandom_range(0, 30);
            end else begin
                i_out_stall <= 1'b1;
                hold_left = gap_len();
            end
        end
    end

    // watchdog
    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("[symmetric_fir_filter] ERROR");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        static t_sample directed [] = '{
            FULL_POS, 16'sd0, 16'sd0, 16'sd0, FULL_NEG, 16'sd0, 16'sd0,
            16'sd1, -16'sd1, 16'sh5555, 16'shaaaa, FULL_POS, FULL_NEG, FULL_POS,
            FULL_NEG, 16'sd1, -16'sd1, 16'sh4000, 16'shc000, 16'sd0
        };
        t_seg kind;
        int   len;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        sent        = 0;
        idle_on     = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, impulses and sign patterns
        foreach (directed[i])
            send_sample(directed[i]);
        wait_drained();

        // random segments, full-scale runs long enough to saturate
        while (sent < ITEMS + directed.size()) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: kind = SEG_UNIFORM;
                4, 5:       kind = SEG_SMALL;
                6:          kind = SEG_POS_FULL;
                7:          kind = SEG_NEG_FULL;
                8:          kind = SEG_ALTERNATE;
                default:    kind = SEG_NEAR_FULL;
            endcase
            len = (kind == SEG_POS_FULL || kind == SEG_NEG_FULL) ? $urandom_range(60, 120)
                                                                 : $urandom_range(10, 80);
            idle_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len; i++)
                send_sample(seg_sample(kind, i));
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        // drain and let the pipeline settle
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fails == 0 && pending == 0)
            $display("[symmetric_fir_filter] OK");
        else
            $display("[symmetric_fir_filter] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/sfir_pkg.sv
rtl/core/sfir_mem.sv
rtl/core/sfir_ctrl.sv
rtl/core/sfir_mac.sv
rtl/core/symmetric_fir_filter.sv
tb/sfir_checker.sv
tb/tb.sv
